// ----- rtl/core/lew_pkg.sv -----
// Package for the line editor with word wrap.
// Holds the line size, byte codes, register indexes, state types and the
// redraw header table. No dependencies.
`default_nettype none

package lew_pkg;

  localparam int LINE_WIDTH = 40;
  localparam int LEN_W      = $clog2(LINE_WIDTH + 1);
  localparam int ADDR_W     = $clog2(LINE_WIDTH);
  localparam int HC_W       = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] CHAR_NUL     = 8'd0;
  localparam logic [7:0] CHAR_BELL    = 8'd7;
  localparam logic [7:0] CHAR_NL      = 8'd10;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_ESC     = 8'd27;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_LBRACK  = 8'd91;
  localparam logic [7:0] CHAR_K       = 8'd75;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;

  localparam logic [7:0] ERASE_RESET  = 8'd127;
  localparam logic [7:0] KILL_RESET   = 8'd21;
  localparam logic [7:0] WERASE_RESET = 8'd23;
  localparam logic [7:0] EOF_RESET    = 8'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ERASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WERASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EOF    = 2'd3;

  localparam logic [HC_W-1:0] HC_K_POS    = 3'd3;
  localparam logic [HC_W-1:0] HC_KILL_END = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_HDR,
    ST_BODY_RD,
    ST_BODY_EM,
    ST_NL,
    ST_TAIL_RD,
    ST_TAIL_EM,
    ST_ONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_REDRAW,
    MODE_KILL,
    MODE_WERASE,
    MODE_WRAP
  } mode_t;

  function automatic logic [7:0] hdr_byte(input logic [HC_W-1:0] hc);
    logic [7:0] b;
    case (hc)
      3'd0: b = CHAR_CR;
      3'd1: b = CHAR_ESC;
      3'd2: b = CHAR_LBRACK;
      3'd3: b = CHAR_K;
      default: b = CHAR_CR;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/line_editor_word_wrap_unit.sv -----
// Line editor with word wrap: keeps one line of printable characters and
// emits terminal bytes for each typed byte but an erase on an empty line. Uses lew_pkg.
// A single-byte reply passes the state register and then the output register
// after the item is taken; each stored character that is redrawn, scanned or
// moved goes through the registered read of the line memory.
// Items are taken one at a time: in_stall is high while the unit is not idle,
// and out_stall can hold each output byte.
// Reset (rst, synchronous): empty line, registers at their defaults, idle.
`default_nettype none

module line_editor_word_wrap_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [lew_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_char,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_byte,
  output logic                               end_of_input,
  output logic                               last_of_run
);

  localparam int LW = lew_pkg::LEN_W;
  localparam int AW = lew_pkg::ADDR_W;
  localparam logic [LW-1:0] FULL = LW'(lew_pkg::LINE_WIDTH);

  logic [7:0] erase_char, kill_char, word_erase_char, eof_char;

  lew_pkg::state_t state, state_next;
  lew_pkg::mode_t  mode, mode_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [LW-1:0] kpos, kpos_next;
  logic [lew_pkg::HC_W-1:0] hc, hc_next;
  logic phase, phase_next;
  logic [7:0] pend, pend_next;
  logic pend_end, pend_end_next;

  logic [7:0] line_mem [lew_pkg::LINE_WIDTH];
  logic [7:0] rdata;
  logic mem_we, rd_en;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic out_load, load_end, load_last, free, is_space, body_end, hdr_last;
  logic [7:0] load_byte;
  logic [LW-1:0] idx_dec, idx_inc, tail_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      erase_char      <= lew_pkg::ERASE_RESET;
      kill_char       <= lew_pkg::KILL_RESET;
      word_erase_char <= lew_pkg::WERASE_RESET;
      eof_char        <= lew_pkg::EOF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lew_pkg::CFG_ERASE:  erase_char      <= cfg_data;
        lew_pkg::CFG_KILL:   kill_char       <= cfg_data;
        lew_pkg::CFG_WERASE: word_erase_char <= cfg_data;
        lew_pkg::CFG_EOF:    eof_char        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= line_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lew_pkg::ST_IDLE;
      mode     <= lew_pkg::MODE_REDRAW;
      len      <= '0;
      idx      <= '0;
      cnt      <= '0;
      kpos     <= '0;
      hc       <= '0;
      phase    <= 1'b0;
      pend_end <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      len      <= len_next;
      idx      <= idx_next;
      cnt      <= cnt_next;
      kpos     <= kpos_next;
      hc       <= hc_next;
      phase    <= phase_next;
      pend_end <= pend_end_next;
    end
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_byte     <= load_byte;
      end_of_input <= load_end;
      last_of_run  <= load_last;
    end
  end

  assign in_stall = (state != lew_pkg::ST_IDLE);
  assign free     = !out_valid || !out_stall;
  assign is_space = (rdata == lew_pkg::CHAR_SPACE);
  assign idx_dec  = idx - 1'b1;
  assign idx_inc  = idx + 1'b1;
  assign tail_sum = kpos + idx;
  assign body_end = (idx_inc == cnt);
  assign hdr_last = ((mode == lew_pkg::MODE_KILL) && (hc == lew_pkg::HC_KILL_END)) ||
                    ((mode == lew_pkg::MODE_REDRAW) && (hc == lew_pkg::HC_K_POS) &&
                     (cnt == '0));

  always_comb begin
    state_next    = state;
    mode_next     = mode;
    len_next      = len;
    idx_next      = idx;
    cnt_next      = cnt;
    kpos_next     = kpos;
    hc_next       = hc;
    phase_next    = phase;
    pend_next     = pend;
    pend_end_next = pend_end;
    mem_we        = 1'b0;
    waddr         = '0;
    wdata         = '0;
    rd_en         = 1'b0;
    raddr         = '0;
    out_load      = 1'b0;
    load_byte     = '0;
    load_end      = 1'b0;
    load_last     = 1'b0;

    case (state)
      lew_pkg::ST_IDLE: begin
        if (in_valid) begin
          pend_next     = in_char;
          pend_end_next = 1'b0;
          hc_next       = '0;
          if (in_char == erase_char) begin
            if (len != '0) begin
              len_next   = len - 1'b1;
              cnt_next   = len - 1'b1;
              mode_next  = lew_pkg::MODE_REDRAW;
              state_next = lew_pkg::ST_HDR;
            end
          end else if (in_char == kill_char) begin
            len_next   = '0;
            mode_next  = lew_pkg::MODE_KILL;
            state_next = lew_pkg::ST_HDR;
          end else if (in_char == word_erase_char) begin
            idx_next   = len;
            phase_next = 1'b0;
            mode_next  = lew_pkg::MODE_WERASE;
            state_next = lew_pkg::ST_SCAN_RD;
          end else if ((in_char == eof_char) && (len == '0)) begin
            pend_next     = lew_pkg::CHAR_NUL;
            pend_end_next = 1'b1;
            state_next    = lew_pkg::ST_ONE;
          end else if (in_char == lew_pkg::CHAR_NL) begin
            len_next   = '0;
            state_next = lew_pkg::ST_ONE;
          end else if (in_char inside {[lew_pkg::PRINT_LO:lew_pkg::PRINT_HI]}) begin
            if (len >= FULL) begin
              idx_next   = FULL;
              mode_next  = lew_pkg::MODE_WRAP;
              state_next = lew_pkg::ST_SCAN_RD;
            end else begin
              mem_we     = 1'b1;
              waddr      = len[AW-1:0];
              wdata      = in_char;
              len_next   = len + 1'b1;
              state_next = lew_pkg::ST_ONE;
            end
          end else begin
            pend_next  = lew_pkg::CHAR_BELL;
            state_next = lew_pkg::ST_ONE;
          end
        end
      end

      lew_pkg::ST_SCAN_RD: begin
        if (idx == '0) begin
          if (mode == lew_pkg::MODE_WERASE) begin
            if (phase) begin
              len_next = '0;
              cnt_next = '0;
            end else begin
              cnt_next = len;
            end
            hc_next    = '0;
            mode_next  = lew_pkg::MODE_REDRAW;
            state_next = lew_pkg::ST_HDR;
          end else begin
            kpos_next  = '0;
            state_next = lew_pkg::ST_NL;
          end
        end else begin
          rd_en      = 1'b1;
          raddr      = idx_dec[AW-1:0];
          state_next = lew_pkg::ST_SCAN_CHK;
        end
      end

      lew_pkg::ST_SCAN_CHK: begin
        if (mode == lew_pkg::MODE_WERASE) begin
          if (!phase) begin
            idx_next = idx_dec;
            if (!is_space) begin
              phase_next = 1'b1;
            end
            state_next = lew_pkg::ST_SCAN_RD;
          end else if (!is_space) begin
            idx_next   = idx_dec;
            state_next = lew_pkg::ST_SCAN_RD;
          end else begin
            len_next   = idx;
            cnt_next   = idx;
            hc_next    = '0;
            mode_next  = lew_pkg::MODE_REDRAW;
            state_next = lew_pkg::ST_HDR;
          end
        end else begin
          if (is_space) begin
            kpos_next  = idx;
            cnt_next   = idx;
            hc_next    = '0;
            state_next = lew_pkg::ST_HDR;
          end else begin
            idx_next   = idx_dec;
            state_next = lew_pkg::ST_SCAN_RD;
          end
        end
      end

      lew_pkg::ST_HDR: begin
        if (free) begin
          out_load  = 1'b1;
          load_byte = lew_pkg::hdr_byte(hc);
          load_last = hdr_last;
          if (hdr_last) begin
            state_next = lew_pkg::ST_IDLE;
          end else if ((hc == lew_pkg::HC_K_POS) && (mode != lew_pkg::MODE_KILL)) begin
            idx_next   = '0;
            state_next = lew_pkg::ST_BODY_RD;
          end else begin
            hc_next = hc + 1'b1;
          end
        end
      end

      lew_pkg::ST_BODY_RD: begin
        rd_en      = 1'b1;
        raddr      = idx[AW-1:0];
        state_next = lew_pkg::ST_BODY_EM;
      end

      lew_pkg::ST_BODY_EM: begin
        if (free) begin
          out_load  = 1'b1;
          load_byte = rdata;
          load_last = (mode == lew_pkg::MODE_REDRAW) && body_end;
          idx_next  = idx_inc;
          if (!body_end) begin
            state_next = lew_pkg::ST_BODY_RD;
          end else if (mode == lew_pkg::MODE_REDRAW) begin
            state_next = lew_pkg::ST_IDLE;
          end else begin
            state_next = lew_pkg::ST_NL;
          end
        end
      end

      lew_pkg::ST_NL: begin
        if (free) begin
          out_load  = 1'b1;
          load_byte = lew_pkg::CHAR_NL;
          if (kpos == '0) begin
            mem_we     = 1'b1;
            waddr      = '0;
            wdata      = pend;
            len_next   = LW'(1);
            state_next = lew_pkg::ST_ONE;
          end else begin
            idx_next   = '0;
            state_next = lew_pkg::ST_TAIL_RD;
          end
        end
      end

      lew_pkg::ST_TAIL_RD: begin
        if (tail_sum == FULL) begin
          mem_we     = 1'b1;
          waddr      = idx[AW-1:0];
          wdata      = pend;
          len_next   = idx_inc;
          state_next = lew_pkg::ST_ONE;
        end else begin
          rd_en      = 1'b1;
          raddr      = tail_sum[AW-1:0];
          state_next = lew_pkg::ST_TAIL_EM;
        end
      end

      lew_pkg::ST_TAIL_EM: begin
        if (free) begin
          out_load   = 1'b1;
          load_byte  = rdata;
          mem_we     = 1'b1;
          waddr      = idx[AW-1:0];
          wdata      = rdata;
          idx_next   = idx_inc;
          state_next = lew_pkg::ST_TAIL_RD;
        end
      end

      lew_pkg::ST_ONE: begin
        if (free) begin
          out_load   = 1'b1;
          load_byte  = pend;
          load_end   = pend_end;
          load_last  = 1'b1;
          state_next = lew_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lew_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
